// ----- design/assert_macros.svh -----
// Assertion macros for the nearest palette color search RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_AT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ----- design/nps_pkg.sv -----
// Package with the types, constants and command codes of the palette search.
package nps_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int ADDR_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	// Wide enough for an 8-bit entry index and for PALETTE_ENTRIES itself.
	localparam int CMP_W = (ADDR_W + 1 > 8) ? ADDR_W + 1 : 8;
	localparam int COLOR_W = 8;
	localparam int ENTRY_W = 3 * COLOR_W;
	localparam int SQ_W = 2 * COLOR_W;
	localparam int DIST_W = 18;
	localparam logic [DIST_W-1:0] DIST_INIT = '1;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PALETTE_ENTRIES - 1);

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_QUERY = 1'b1
	} nps_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} nps_state_t;

	typedef struct packed {
		logic              load;
		logic              start;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              out_load;
	} nps_cmd_t;

	typedef struct packed {
		logic busy;
	} nps_stat_t;

endpackage

// ----- design/nps_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module nps_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             re,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (re) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- design/nps_dp.sv -----
// Datapath: palette memory, distance pipeline, best-match tracking and result register.
module nps_dp
	import nps_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  nps_cmd_t            cmd,
	output nps_stat_t           stat,
	input  logic [7:0]          entry_index,
	input  logic [COLOR_W-1:0]  red,
	input  logic [COLOR_W-1:0]  green,
	input  logic [COLOR_W-1:0]  blue,
	output logic [7:0]          best_index,
	output logic [DIST_W-1:0]   best_distance,
	output logic                exact_match
);

	logic [CMP_W-1:0]   idx_ext;
	logic               load_ok;
	logic [ENTRY_W-1:0] rd_data_s1;
	logic               v_s1, v_s2;
	logic [ADDR_W-1:0]  idx_s1, idx_s2;
	logic [COLOR_W-1:0] qr_q, qg_q, qb_q;
	logic [COLOR_W-1:0] dr, dg, db;
	logic [SQ_W-1:0]    sq_r_s2, sq_g_s2, sq_b_s2;
	logic [DIST_W-1:0]  cand_d;
	logic [DIST_W-1:0]  best_d_q;
	logic [ADDR_W-1:0]  best_i_q;
	logic [7:0]         out_idx_q;
	logic [DIST_W-1:0]  out_dist_q;
	logic               out_exact_q;

	// Loads beyond the palette are dropped.
	assign idx_ext = CMP_W'(entry_index);
	assign load_ok = idx_ext < CMP_W'(PALETTE_ENTRIES);

	nps_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(PALETTE_ENTRIES)
	) u_ram (
		.clk    (clk),
		.we     (cmd.load && load_ok),
		.wr_addr(ADDR_W'(idx_ext)),
		.wr_data({red, green, blue}),
		.re     (cmd.rd_en),
		.rd_addr(cmd.rd_addr),
		.rd_data(rd_data_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			qr_q <= red;
			qg_q <= green;
			qb_q <= blue;
		end
	end

	always_comb begin
		dr = (rd_data_s1[ENTRY_W-1 -: COLOR_W] > qr_q) ?
			rd_data_s1[ENTRY_W-1 -: COLOR_W] - qr_q : qr_q - rd_data_s1[ENTRY_W-1 -: COLOR_W];
		dg = (rd_data_s1[2*COLOR_W-1 -: COLOR_W] > qg_q) ?
			rd_data_s1[2*COLOR_W-1 -: COLOR_W] - qg_q : qg_q - rd_data_s1[2*COLOR_W-1 -: COLOR_W];
		db = (rd_data_s1[COLOR_W-1:0] > qb_q) ?
			rd_data_s1[COLOR_W-1:0] - qb_q : qb_q - rd_data_s1[COLOR_W-1:0];
	end

	always_ff @(posedge clk) begin
		idx_s1  <= cmd.rd_addr;
		idx_s2  <= idx_s1;
		sq_r_s2 <= SQ_W'(dr) * SQ_W'(dr);
		sq_g_s2 <= SQ_W'(dg) * SQ_W'(dg);
		sq_b_s2 <= SQ_W'(db) * SQ_W'(db);
	end

	assign cand_d = DIST_W'(sq_r_s2) + DIST_W'(sq_g_s2) + DIST_W'(sq_b_s2);

	// Strict compare keeps the lowest index on a tie.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			best_d_q <= DIST_INIT;
			best_i_q <= '0;
		end else if (v_s2 && (cand_d < best_d_q)) begin
			best_d_q <= cand_d;
			best_i_q <= idx_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_idx_q   <= 8'(CMP_W'(best_i_q));
			out_dist_q  <= best_d_q;
			out_exact_q <= (best_d_q == '0);
		end
	end

	assign stat.busy     = v_s1 | v_s2;
	assign best_index    = out_idx_q;
	assign best_distance = out_dist_q;
	assign exact_match   = out_exact_q;

endmodule

// ----- design/nps_ctrl.sv -----
// Controller: accepts requests, sequences the palette scan and owns the result valid.
`include "assert_macros.svh"

module nps_ctrl
	import nps_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  nps_op_t   op,
	output logic      out_valid,
	input  logic      out_ready,
	output nps_cmd_t  cmd,
	input  nps_stat_t stat
);

	nps_state_t        state_q, state_nxt;
	logic [ADDR_W-1:0] cnt_q, cnt_nxt;
	logic              out_valid_q;
	logic              out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			cnt_q   <= cnt_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt    = state_q;
		cnt_nxt      = cnt_q;
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.rd_addr  = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.load  = in_valid && (op == CMD_LOAD);
				cmd.start = in_valid && (op == CMD_QUERY);
				if (cmd.start) begin
					state_nxt = ST_SCAN;
					cnt_nxt   = '0;
				end
			end
			ST_SCAN: begin
				cmd.rd_en = 1'b1;
				if (cnt_q == LAST_ADDR) begin
					cnt_nxt   = '0;
					state_nxt = ST_DRAIN;
				end else begin
					cnt_nxt = cnt_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				if (!stat.busy && out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	`ASSERT_NEVER(a_no_read_in_idle, clk, arst_n, (state_q == ST_IDLE) && cmd.rd_en)
	`ASSERT_NEVER(a_no_overwrite, clk, arst_n, cmd.out_load && out_valid_q && !out_ready)
	`ASSERT_AT(a_query_starts_scan, clk, arst_n, cmd.start |=> (state_q == ST_SCAN) && (cnt_q == '0))
	`ASSERT_NEVER(a_result_with_pipe_busy, clk, arst_n, cmd.out_load && stat.busy)

endmodule

// ----- design/nearest_palette_color_search_top.sv -----
// Top level of the nearest palette color search: stream ports, controller and datapath.
//
// The block keeps a palette of PALETTE_ENTRIES (256) RGB colors of 8 bits per
// component and answers nearest-color queries against it. A request with
// s_tuser = 0 loads one palette entry at entry_index and produces no result. A
// request with s_tuser = 1 carries a query color and produces one result: the
// lowest palette index at the smallest squared Euclidean distance, that distance,
// and an exact-match flag. A query reads the palette memory one entry per cycle
// through its single read port, and the distance pipeline behind it registers
// the squared differences of the three color components and then the best match
// ahead of the output register; the block takes no new
// request during that scan. The result waits in an output register, so a new
// load or query is accepted while an earlier result is still waiting on m_tready;
// a second query then finishes its scan and holds until that register is free.
// Every palette entry must be loaded before the first query; entries that were
// never written read back as arbitrary colors. Loads with an entry_index at or
// above PALETTE_ENTRIES are dropped. No clearing pass runs after reset.
module nearest_palette_color_search_top
	import nps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
	input  logic [0:0]  s_tuser,  // cmd[0]: 0 load entry, 1 query
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // best_index[7:0], best_distance[25:8], exact_match[26], zero
);

	nps_cmd_t           cmd;
	nps_stat_t          stat;
	nps_op_t            op;
	logic [7:0]         best_index;
	logic [DIST_W-1:0]  best_distance;
	logic               exact_match;

	assign op = nps_op_t'(s_tuser[0]);

	// The controller decides when a request is taken and drives the scan.
	nps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.op       (op),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	// The datapath holds the palette memory and the distance compare.
	nps_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.entry_index  (s_tdata[7:0]),
		.red          (s_tdata[15:8]),
		.green        (s_tdata[23:16]),
		.blue         (s_tdata[31:24]),
		.best_index   (best_index),
		.best_distance(best_distance),
		.exact_match  (exact_match)
	);

	assign m_tdata = {5'b0, exact_match, best_distance, best_index};

endmodule
